>>> design/tmrs_pkg.sv
`timescale 1ns / 1ps
package tmrs_pkg;

    // exp table geometry
    localparam int EXP_TABLE_BITS = 8;
    localparam int FRAC_SHIFT     = 16 - EXP_TABLE_BITS;
    localparam int TAB_LEN        = (1 << EXP_TABLE_BITS) + 1;
    localparam int INT_LEN        = 32;
    localparam int INT_BITS       = $clog2(INT_LEN);
    localparam int SERIES_TERMS   = 14;
    localparam int EXP_W          = 31;

    // field widths
    localparam int U_W    = 16;
    localparam int VB_W   = 21;
    localparam int K_W    = 24;
    localparam int PEAK_W = 32;
    localparam int LEN_W  = 32;
    localparam int VEL_W  = 24;
    localparam int DIST_W = 24;
    localparam int POS_W  = 32;
    localparam int DENS_W = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [EXP_W-1:0] ONE_Q30 = 31'h4000_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_SPEED    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TWO_VTHSQ = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DENSITY  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_LENGTH = 8'd3;

    // reset values
    localparam logic [VB_W-1:0]   RST_BEAM_SPEED    = 21'd262144;
    localparam logic [K_W-1:0]    RST_INV_TWO_VTHSQ = 24'd32768;
    localparam logic [PEAK_W-1:0] RST_PEAK_DENSITY  = 32'd10212922;
    localparam logic [LEN_W-1:0]  RST_DOMAIN_LENGTH = 32'd65536;

    typedef logic [TAB_LEN-1:0][EXP_W-1:0] t_frac_tab;
    typedef logic [INT_LEN-1:0][EXP_W-1:0] t_int_tab;

    // exp(-x), x in [0,1] q0.30, alternating taylor series, elaboration only
    function automatic logic [63:0] series_exp(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << 30;
        pos  = 64'd1 << 30;
        neg  = 64'd0;
        for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * x) >> 30) / 64'(n);
            if (n % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return (pos > neg) ? (pos - neg) : 64'd0;
    endfunction

    function automatic t_frac_tab build_frac_tab();
        t_frac_tab t;
        for (int j = 0; j < TAB_LEN; j++) begin
            t[j] = EXP_W'(series_exp(64'(j) << (30 - EXP_TABLE_BITS)));
        end
        return t;
    endfunction

    // exp(-n), rounded repeated products
    function automatic t_int_tab build_int_tab();
        t_int_tab    t;
        logic [63:0] e1;
        logic [63:0] acc;
        e1   = series_exp(64'd1 << 30);
        acc  = 64'd1 << 30;
        t[0] = EXP_W'(acc);
        for (int j = 1; j < INT_LEN; j++) begin
            acc  = (acc * e1 + (64'd1 << 29)) >> 30;
            t[j] = EXP_W'(acc);
        end
        return t;
    endfunction

    localparam t_frac_tab FRAC_TAB = build_frac_tab();
    localparam t_int_tab  INT_TAB  = build_int_tab();

    // floor(x / 65535) by folding 16-bit digits, exact for x < 2^50
    function automatic logic [33:0] div_by_65535(input logic [49:0] x);
        logic [33:0] q0;
        logic [34:0] r0;
        logic [18:0] q1;
        logic [19:0] r1;
        logic [3:0]  q2;
        logic [16:0] r2;
        logic        q3;
        q0 = x[49:16];
        r0 = {19'd0, x[15:0]} + {1'b0, q0};
        q1 = r0[34:16];
        r1 = {4'd0, r0[15:0]} + {1'b0, q1};
        q2 = r1[19:16];
        r2 = {1'b0, r1[15:0]} + {13'd0, q2};
        q3 = (r2 >= 17'd65535);
        return q0 + {15'd0, q1} + {30'd0, q2} + {33'd0, q3};
    endfunction

endpackage

>>> design/tmrs_gauss.sv
`timescale 1ns / 1ps
// exp(-d^2 * k) in q0.30, five register stages
module tmrs_gauss (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [tmrs_pkg::DIST_W-1:0]      i_dist,
    input  logic [tmrs_pkg::K_W-1:0]         i_k,
    output logic [tmrs_pkg::EXP_W-1:0]       o_exp
);

    localparam int FS = tmrs_pkg::FRAC_SHIFT;
    localparam int TB = tmrs_pkg::EXP_TABLE_BITS;
    localparam int EW = tmrs_pkg::EXP_W;
    localparam int IB = tmrs_pkg::INT_BITS;

    logic [47:0]    w_sq;
    logic [31:0]    r_sq;
    logic [55:0]    w_arg;
    logic [39:0]    r_arg;

    logic [TB-1:0]  w_idx;
    logic [TB:0]    w_idx_nx;
    logic [EW-1:0]  w_hi;
    logic [EW-1:0]  w_lo;
    logic [EW-1:0]  r_hi;
    logic [EW-1:0]  r_diff;
    logic [FS-1:0]  r_rem;
    logic [IB-1:0]  r_kint;
    logic           r_big;

    logic [EW+FS-1:0] w_corr;
    logic [EW-1:0]  r_fe;
    logic [IB-1:0]  r_kint2;
    logic           r_big2;

    logic [61:0]    w_scaled;
    logic [EW-1:0]  r_exp;

    assign w_sq  = 48'(i_dist) * 48'(i_dist);
    assign w_arg = 56'(r_sq) * 56'(i_k);

    // fraction split: table index and interpolation weight
    assign w_idx    = r_arg[15:FS];
    assign w_idx_nx = {1'b0, w_idx} + (TB+1)'(1);
    assign w_hi     = tmrs_pkg::FRAC_TAB[w_idx];
    assign w_lo     = tmrs_pkg::FRAC_TAB[w_idx_nx];

    assign w_corr   = (EW+FS)'(r_diff) * (EW+FS)'(r_rem);
    assign w_scaled = 62'(tmrs_pkg::INT_TAB[r_kint2]) * 62'(r_fe);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq    <= w_sq[47:16];
            r_arg   <= w_arg[55:16];
            r_hi    <= w_hi;
            r_diff  <= (w_hi > w_lo) ? (w_hi - w_lo) : '0;
            r_rem   <= r_arg[FS-1:0];
            r_kint  <= r_arg[16 +: IB];
            r_big   <= |r_arg[39:16+IB];
            r_fe    <= r_hi - EW'(w_corr >> FS);
            r_kint2 <= r_kint;
            r_big2  <= r_big;
            r_exp   <= r_big2 ? '0 : w_scaled[EW+29:30];
        end
    end

    assign o_exp = r_exp;

endmodule

>>> design/two_stream_maxwellian_rejection_sampler_unit.sv
`timescale 1ns / 1ps
// pipeline: eleven register stages from input transaction to result on the master
//   side, with the input transaction loading the first
// throughput: one trial per cycle; all stages advance on one shared enable,
//   open whenever the output register is empty or being drained
// reset: i_rst_n synchronous active low, empties the pipeline and loads the
//   default beam, thermal, peak and length registers
module two_stream_maxwellian_rejection_sampler_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tmrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tmrs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // trial stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] uniform_speed, [31:16] uniform_place, [47:32] uniform_trial
    input  logic [47:0]                        s_axis_tdata,
    // result stream out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [23:0] velocity, [55:24] position, [87:56] density
    output logic [87:0]                        m_axis_tdata,
    // [0] accepted
    output logic                               m_axis_tuser
);

    localparam int STAGES = 11;
    localparam int GDLY   = 5;    // depth of the gauss units
    localparam int U_W    = tmrs_pkg::U_W;
    localparam int VB_W   = tmrs_pkg::VB_W;
    localparam int EW     = tmrs_pkg::EXP_W;
    localparam int DW     = tmrs_pkg::DIST_W;

    // config registers
    logic [VB_W-1:0]              r_beam_speed;
    logic [tmrs_pkg::K_W-1:0]     r_inv_two_vthsq;
    logic [tmrs_pkg::PEAK_W-1:0]  r_peak_density;
    logic [tmrs_pkg::LEN_W-1:0]   r_domain_length;

    // pipeline control
    logic [STAGES-1:0]            r_vld;
    logic                         w_adv;

    // stage 1: products for velocity and position
    logic [U_W-1:0]               w_us;
    logic [U_W-1:0]               w_up;
    logic [U_W-1:0]               w_ut;
    logic [36:0]                  r1_prod_v;
    logic [47:0]                  r1_prod_p;
    logic [U_W-1:0]               r1_ut;

    // stage 2: divide by 65535
    logic [33:0]                  w_qv;
    logic [33:0]                  w_qp;
    logic [DW-1:0]                r2_qv;
    logic [tmrs_pkg::POS_W-1:0]   r2_pos;
    logic [U_W-1:0]               r2_ut;

    // stage 3: velocity and distances to both beams
    logic signed [24:0]           w_v;
    logic signed [25:0]           w_d1;
    logic signed [25:0]           w_d2;
    logic [25:0]                  w_a1;
    logic [25:0]                  w_a2;
    logic [tmrs_pkg::VEL_W-1:0]   r3_vel;
    logic [DW-1:0]                r3_d0;
    logic [DW-1:0]                r3_d1;
    logic [DW-1:0]                r3_d2;
    logic [tmrs_pkg::POS_W-1:0]   r3_pos;
    logic [U_W-1:0]               r3_ut;

    // side data riding along the gauss units
    logic [tmrs_pkg::VEL_W-1:0]   r_vel_dly [GDLY];
    logic [tmrs_pkg::POS_W-1:0]   r_pos_dly [GDLY];
    logic [U_W-1:0]               r_ut_dly  [GDLY];
    logic [EW-1:0]                w_e0;
    logic [EW-1:0]                w_e1;
    logic [EW-1:0]                w_e2;

    // stage 9: density and peak
    logic [31:0]                  w_esum;
    logic [31:0]                  w_emax;
    logic [63:0]                  w_fprod;
    logic [63:0]                  w_mprod;
    logic [33:0]                  r9_f;
    logic [32:0]                  r9_fmax;
    logic [tmrs_pkg::VEL_W-1:0]   r9_vel;
    logic [tmrs_pkg::POS_W-1:0]   r9_pos;
    logic [U_W-1:0]               r9_ut;

    // stage 10: scaled peak product
    logic [49:0]                  r10_wprod;
    logic [33:0]                  r10_f;
    logic [tmrs_pkg::VEL_W-1:0]   r10_vel;
    logic [tmrs_pkg::POS_W-1:0]   r10_pos;

    // stage 11: output register
    logic [33:0]                  w_w;
    logic                         r_acc;
    logic [tmrs_pkg::VEL_W-1:0]   r_vel;
    logic [tmrs_pkg::POS_W-1:0]   r_pos;
    logic [tmrs_pkg::DENS_W-1:0]  r_dens;

    // config writes always taken, unknown indexes dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_speed    <= tmrs_pkg::RST_BEAM_SPEED;
            r_inv_two_vthsq <= tmrs_pkg::RST_INV_TWO_VTHSQ;
            r_peak_density  <= tmrs_pkg::RST_PEAK_DENSITY;
            r_domain_length <= tmrs_pkg::RST_DOMAIN_LENGTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tmrs_pkg::CFG_BEAM_SPEED: begin
                    r_beam_speed <= i_cfg_data[VB_W-1:0];
                end
                tmrs_pkg::CFG_INV_TWO_VTHSQ: begin
                    r_inv_two_vthsq <= i_cfg_data[tmrs_pkg::K_W-1:0];
                end
                tmrs_pkg::CFG_PEAK_DENSITY: begin
                    r_peak_density <= i_cfg_data[tmrs_pkg::PEAK_W-1:0];
                end
                tmrs_pkg::CFG_DOMAIN_LENGTH: begin
                    r_domain_length <= i_cfg_data[tmrs_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // whole pipe moves together unless the result register is stuck
    assign w_adv         = !r_vld[STAGES-1] || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[STAGES-2:0], s_axis_tvalid};
        end
    end

    assign w_us = s_axis_tdata[15:0];
    assign w_up = s_axis_tdata[31:16];
    assign w_ut = s_axis_tdata[47:32];

    assign w_qv = tmrs_pkg::div_by_65535({10'd0, r1_prod_v, 3'b000});
    assign w_qp = tmrs_pkg::div_by_65535({2'd0, r1_prod_p});

    // v = floor(8 vb us / 65535) - 4 vb
    assign w_v  = $signed({1'b0, r2_qv}) - $signed({2'b00, r_beam_speed, 2'b00});
    assign w_d1 = $signed({w_v[24], w_v}) - $signed({5'd0, r_beam_speed});
    assign w_d2 = $signed({w_v[24], w_v}) + $signed({5'd0, r_beam_speed});
    assign w_a1 = w_d1[25] ? (~w_d1 + 26'd1) : w_d1;
    assign w_a2 = w_d2[25] ? (~w_d2 + 26'd1) : w_d2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_prod_v <= 37'(r_beam_speed) * 37'(w_us);
            r1_prod_p <= 48'(r_domain_length) * 48'(w_up);
            r1_ut     <= w_ut;

            r2_qv     <= w_qv[DW-1:0];
            r2_pos    <= w_qp[tmrs_pkg::POS_W-1:0];
            r2_ut     <= r1_ut;

            r3_vel    <= w_v[tmrs_pkg::VEL_W-1:0];
            r3_d0     <= {2'b00, r_beam_speed, 1'b0};
            r3_d1     <= w_a1[DW-1:0];
            r3_d2     <= w_a2[DW-1:0];
            r3_pos    <= r2_pos;
            r3_ut     <= r2_ut;

            r_vel_dly[0] <= r3_vel;
            r_pos_dly[0] <= r3_pos;
            r_ut_dly[0]  <= r3_ut;
            for (int i = 1; i < GDLY; i++) begin
                r_vel_dly[i] <= r_vel_dly[i-1];
                r_pos_dly[i] <= r_pos_dly[i-1];
                r_ut_dly[i]  <= r_ut_dly[i-1];
            end
        end
    end

    // three exp evaluations: both beams and the peak term at distance 2 vb
    tmrs_gauss u_gauss_peak (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_dist (r3_d0),
        .i_k    (r_inv_two_vthsq),
        .o_exp  (w_e0)
    );

    tmrs_gauss u_gauss_lo (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_dist (r3_d1),
        .i_k    (r_inv_two_vthsq),
        .o_exp  (w_e1)
    );

    tmrs_gauss u_gauss_hi (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_dist (r3_d2),
        .i_k    (r_inv_two_vthsq),
        .o_exp  (w_e2)
    );

    // f = peak (e1 + e2) >> 30, fmax = peak (1 + e0) >> 30
    assign w_esum  = {1'b0, w_e1} + {1'b0, w_e2};
    assign w_emax  = {1'b0, tmrs_pkg::ONE_Q30} + {1'b0, w_e0};
    assign w_fprod = {32'd0, r_peak_density} * {32'd0, w_esum};
    assign w_mprod = {32'd0, r_peak_density} * {32'd0, w_emax};

    // trial height w = floor(fmax ut / 65535)
    assign w_w = tmrs_pkg::div_by_65535(r10_wprod);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_f      <= w_fprod[63:30];
            r9_fmax   <= w_mprod[62:30];
            r9_vel    <= r_vel_dly[GDLY-1];
            r9_pos    <= r_pos_dly[GDLY-1];
            r9_ut     <= r_ut_dly[GDLY-1];

            r10_wprod <= 50'(r9_fmax) * 50'(r9_ut);
            r10_f     <= r9_f;
            r10_vel   <= r9_vel;
            r10_pos   <= r9_pos;

            // acceptance on full width, density output saturates
            r_acc     <= (w_w < r10_f);
            r_vel     <= r10_vel;
            r_pos     <= r10_pos;
            r_dens    <= (|r10_f[33:32]) ? '1 : r10_f[31:0];
        end
    end

    assign m_axis_tvalid = r_vld[STAGES-1];
    assign m_axis_tdata  = {r_dens, r_pos, r_vel};
    assign m_axis_tuser  = r_acc;

    // reset empties the result register
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled pipe keeps every in-flight trial
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> r_vld == $past(r_vld))
        else $error("valid bits moved during stall");

    // acceptance means w < f, so the density is at least one
    a_accept_density: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[87:56] != 32'd0)
        else $error("accepted trial with zero density");

    // stall comes only from the output side
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

>>> tb/tb_two_stream_maxwellian_rejection_sampler_unit.sv
`timescale 1ns / 1ps
module tb_two_stream_maxwellian_rejection_sampler_unit;

    localparam int LATENCY      = 10;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic        accepted;
        logic [23:0] velocity;
        logic [31:0] position;
        logic [31:0] density;
    } t_sample;

    typedef struct packed {
        logic [15:0] speed;
        logic [15:0] place;
        logic [15:0] trial;
        logic        known;
        t_sample     result;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [tmrs_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tmrs_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [15:0] uniform_speed, [31:16] uniform_place, [47:32] uniform_trial
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [23:0] velocity, [55:24] position, [87:56] density
    logic [87:0] m_axis_tdata;
    // [0] accepted
    logic        m_axis_tuser;

    two_stream_maxwellian_rejection_sampler_unit u_top (.*);

    // predictor copy of the registers and exp tables
    logic [20:0] beam_q;
    logic [23:0] kcoef_q;
    logic [31:0] peak_q;
    logic [31:0] len_q;
    logic [63:0] frac_lut [tmrs_pkg::TAB_LEN];
    logic [63:0] whole_lut [tmrs_pkg::INT_LEN];

    t_sample sample_fifo [$];
    int      fail_count;
    int      seen_count;
    longint  cycle_count;
    bit      stall_burst;
    bit      idle_free;

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] taylor_decay(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        term  = 64'd1 << 30;
        plus  = term;
        minus = 0;
        for (int n = 1; n <= tmrs_pkg::SERIES_TERMS; n++) begin
            term = ((term * x) >> 30) / 64'(n);
            if (n % 2 == 1) begin
                minus += term;
            end else begin
                plus += term;
            end
        end
        return (plus > minus) ? plus - minus : 64'd0;
    endfunction

    // exp(-a), a in q.16, result q0.30
    function automatic logic [63:0] decay_of(input logic [63:0] a);
        logic [63:0] whole;
        logic [63:0] part;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] diff;
        whole = a >> 16;
        if (whole >= 64'(tmrs_pkg::INT_LEN)) return 64'd0;
        part = a & 64'hFFFF;
        idx  = part >> tmrs_pkg::FRAC_SHIFT;
        rem  = part & ((64'd1 << tmrs_pkg::FRAC_SHIFT) - 64'd1);
        hi   = frac_lut[idx];
        lo   = frac_lut[idx + 1];
        diff = (hi > lo) ? hi - lo : 64'd0;
        return (whole_lut[whole] * (hi - ((diff * rem) >> tmrs_pkg::FRAC_SHIFT))) >> 30;
    endfunction

    function automatic logic [63:0] gauss_at(input logic [63:0] span);
        logic [63:0] sq;
        sq = span * span;
        return decay_of(((sq >> 16) * kcoef_q) >> 16);
    endfunction

    function automatic t_sample predict_sample(input logic [15:0] us, input logic [15:0] up,
                                               input logic [15:0] ut);
        t_sample      s;
        longint       vel;
        longint       d1;
        longint       d2;
        logic [127:0] dens;
        logic [127:0] peak_max;
        logic [127:0] height;
        logic [63:0]  e_lo;
        logic [63:0]  e_hi;
        logic [63:0]  e_mid;
        vel = longint'((64'd8 * beam_q * us) / 65535) - 4 * longint'(beam_q);
        d1  = vel - longint'(beam_q);
        d2  = vel + longint'(beam_q);
        e_lo  = gauss_at(d1 < 0 ? -d1 : d1);
        e_hi  = gauss_at(d2 < 0 ? -d2 : d2);
        e_mid = gauss_at(64'd2 * beam_q);
        dens     = (128'(peak_q) * (e_lo + e_hi)) >> 30;
        peak_max = (128'(peak_q) * ((64'd1 << 30) + e_mid)) >> 30;
        height   = (peak_max * ut) / 65535;
        s.accepted = height < dens;
        s.velocity = vel[23:0];
        s.position = 32'((64'(len_q) * up) / 65535);
        s.density  = (dens > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : dens[31:0];
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 seen_count);
        fail_count++;
    endtask

    // result checker, with the stall pattern driven from the same process
    always @(posedge i_clk) begin
        t_sample got;
        t_sample want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[55:24],
                    m_axis_tdata[87:56]};
            if (sample_fifo.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(got), 64'd0);
            end else begin
                want = sample_fifo.pop_front();
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
                if (got.velocity !== want.velocity)
                    report_mismatch("velocity", 64'(got.velocity), 64'(want.velocity));
                if (got.position !== want.position)
                    report_mismatch("position", 64'(got.position), 64'(want.position));
                if (got.density !== want.density)
                    report_mismatch("density", 64'(got.density), 64'(want.density));
            end
            seen_count++;
        end
        m_axis_tready <= stall_burst ? 1'b0 : (idle_free || $urandom_range(99) >= 9);
    end

    initial begin
        if (cycle_count == 0) begin
        end
        forever begin
            @(posedge i_clk);
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("two_stream_maxwellian_rejection_sampler_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [tmrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tmrs_pkg::CFG_BEAM_SPEED:    beam_q  = val[20:0];
            tmrs_pkg::CFG_INV_TWO_VTHSQ: kcoef_q = val[23:0];
            tmrs_pkg::CFG_PEAK_DENSITY:  peak_q  = val;
            tmrs_pkg::CFG_DOMAIN_LENGTH: len_q   = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_trial(input logic [15:0] us, input logic [15:0] up,
                              input logic [15:0] ut, input bit may_idle);
        if (may_idle && !idle_free) begin
            while ($urandom_range(99) < 9) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ut, up, us};
        do @(posedge i_clk); while (!s_axis_tready);
        sample_fifo.push_back(predict_sample(us, up, ut));
    endtask

    task automatic drain_and_idle();
        s_axis_tvalid <= 1'b0;
        while (sample_fifo.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    t_row directed [] = '{
        '{16'd0,     16'd0,     16'd0,     1'b0, '0},
        '{16'd65535, 16'd65535, 16'd65535, 1'b0, '0},
        '{16'd32767, 16'd12345, 16'd0,     1'b0, '0},
        '{16'd32768, 16'd40000, 16'd65535, 1'b0, '0},
        '{16'd49151, 16'd1,     16'd30000, 1'b0, '0},
        '{16'd16384, 16'd65534, 16'd10,    1'b0, '0},
        '{16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, '0},
        '{16'h5555,  16'hAAAA,  16'h5555,  1'b0, '0}
    };

    initial begin
        logic [31:0] reg_val;
        fail_count    = 0;
        seen_count    = 0;
        cycle_count   = 0;
        stall_burst   = 0;
        idle_free     = 0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        for (int j = 0; j < tmrs_pkg::TAB_LEN; j++)
            frac_lut[j] = taylor_decay(64'(j) << (30 - tmrs_pkg::EXP_TABLE_BITS));
        whole_lut[0] = 64'd1 << 30;
        for (int j = 1; j < tmrs_pkg::INT_LEN; j++)
            whole_lut[j] = (whole_lut[j-1] * frac_lut[tmrs_pkg::TAB_LEN-1]
                            + (64'd1 << 29)) >> 30;
        beam_q  = tmrs_pkg::RST_BEAM_SPEED;
        kcoef_q = tmrs_pkg::RST_INV_TWO_VTHSQ;
        peak_q  = tmrs_pkg::RST_PEAK_DENSITY;
        len_q   = tmrs_pkg::RST_DOMAIN_LENGTH;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: extremes of the speed and place fractions, both beams far away
        directed[0].known  = 1'b1;
        directed[0].result = '{1'b0, 24'hF00000, 32'd0, 32'd0};
        directed[1].known  = 1'b1;
        directed[1].result = '{1'b0, 24'h100000, 32'd65536, 32'd0};
        foreach (directed[r]) begin
            send_trial(directed[r].speed, directed[r].place, directed[r].trial, 0);
            if (directed[r].known) begin
                void'(sample_fifo.pop_back());
                sample_fifo.push_back(directed[r].result);
            end
        end
        drain_and_idle();

        // zero peak: nothing accepted; wide register values and bad indexes
        write_reg(tmrs_pkg::CFG_PEAK_DENSITY, 32'd0);
        write_reg(tmrs_pkg::CFG_BEAM_SPEED, 32'hFFFF_FFFF);
        write_reg(tmrs_pkg::CFG_INV_TWO_VTHSQ, 32'hFFFF_FFFF);
        write_reg(tmrs_pkg::CFG_DOMAIN_LENGTH, 32'hFFFF_FFFF);
        write_reg(tmrs_pkg::CFG_IDX_W'(tmrs_pkg::CFG_DOMAIN_LENGTH + 1), 32'h1234_5678);
        write_reg(8'hFF, 32'h0);
        send_trial(16'd0, 16'd65535, 16'd0, 0);
        send_trial(16'd65535, 16'd32768, 16'd0, 0);
        drain_and_idle();
        // huge peak, tiny k: density overflow
        write_reg(tmrs_pkg::CFG_PEAK_DENSITY, 32'hFFFF_FFFF);
        write_reg(tmrs_pkg::CFG_INV_TWO_VTHSQ, 32'd1);
        write_reg(tmrs_pkg::CFG_BEAM_SPEED, 32'd0);
        send_trial(16'd32768, 16'd100, 16'd0, 0);
        send_trial(16'd0, 16'd200, 16'd65535, 0);
        drain_and_idle();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(tmrs_pkg::CFG_BEAM_SPEED, 32'(tmrs_pkg::RST_BEAM_SPEED));
                    write_reg(tmrs_pkg::CFG_INV_TWO_VTHSQ,
                              32'(tmrs_pkg::RST_INV_TWO_VTHSQ));
                    write_reg(tmrs_pkg::CFG_PEAK_DENSITY, tmrs_pkg::RST_PEAK_DENSITY);
                    write_reg(tmrs_pkg::CFG_DOMAIN_LENGTH, tmrs_pkg::RST_DOMAIN_LENGTH);
                end
                5: begin
                    write_reg(tmrs_pkg::CFG_BEAM_SPEED, 32'h1F_FFFF);
                    write_reg(tmrs_pkg::CFG_INV_TWO_VTHSQ, 32'd1);
                    write_reg(tmrs_pkg::CFG_PEAK_DENSITY, 32'hFFFF_FFFF);
                    write_reg(tmrs_pkg::CFG_DOMAIN_LENGTH, 32'hFFFF_FFFF);
                end
                default: begin
                    reg_val = $urandom_range(2) == 0 ? $urandom : $urandom_range(1 << 19);
                    write_reg(tmrs_pkg::CFG_BEAM_SPEED, reg_val);
                    reg_val = $urandom_range(1) ? $urandom : $urandom_range(1 << 17);
                    write_reg(tmrs_pkg::CFG_INV_TWO_VTHSQ, reg_val);
                    write_reg(tmrs_pkg::CFG_PEAK_DENSITY, $urandom);
                    write_reg(tmrs_pkg::CFG_DOMAIN_LENGTH, $urandom);
                end
            endcase
            idle_free = (ph == 2);
            if (ph == 3) begin
                // long hold-off on the result side while trials keep coming
                fork
                    begin
                        stall_burst = 1;
                        repeat (60) @(posedge i_clk);
                        stall_burst = 0;
                    end
                join_none
            end
            for (int n = 0; n < RANDOM_ITEMS / 6; n++)
                send_trial($urandom, $urandom, $urandom, 1);
            drain_and_idle();
        end

        $display("covered reset defaults, field extremes, zero peak, density overflow,");
        $display("ignored register index and %0d results over six settings", seen_count);
        if (fail_count == 0) begin
            $display("two_stream_maxwellian_rejection_sampler_unit regression: pass");
        end else begin
            $display("two_stream_maxwellian_rejection_sampler_unit regression: fail");
        end
        $finish;
    end

endmodule
